// ===== src/fpe_pkg.sv =====
// ----------------------------------------------------------------------------
// fpe_pkg : shared types and constants for the field-to-power envelope
// Payload structs for the request and response channels, register indexes
// and the table of whole-number exponentials.
// ----------------------------------------------------------------------------
package fpe_pkg;

   typedef struct packed {
      logic [4:0]         channel;
      logic signed [31:0] field_sample;
   } req_type;

   typedef struct packed {
      logic [4:0]  out_channel;
      logic [16:0] power;
   } rsp_type;

   typedef enum logic [1:0] {
      REG_OFFSET  = 2'd0,
      REG_GAIN    = 2'd1,
      REG_CEILING = 2'd2,
      REG_ALPHA   = 2'd3
   } reg_index_type;

   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam int          EXP_INT_LIM  = 11;
   localparam int          TAYLOR_TERMS = 13;

   // round(e^n * 2^16) for n = 0..10
   function automatic logic [31:0] exp_int_q16(input logic [3:0] n);
      logic [31:0] v;
      begin
         case (n)
            4'd0:    v = 32'd65536;
            4'd1:    v = 32'd178145;
            4'd2:    v = 32'd484249;
            4'd3:    v = 32'd1316326;
            4'd4:    v = 32'd3578144;
            4'd5:    v = 32'd9726405;
            4'd6:    v = 32'd26439109;
            4'd7:    v = 32'd71868951;
            4'd8:    v = 32'd195360063;
            4'd9:    v = 32'd531043708;
            4'd10:   v = 32'd1443526462;
            default: v = 32'd0;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== src/field_to_power_envelope.sv =====
// Response timing depends on the path: the back end runs the Taylor sequencer,
// then the bit-serial activity divide unless the sample is screened out or the
// capped exponent is not above one. The back end holds one transaction at a
// time; the front register holds the next request meanwhile.
// Synchronous active-high reset restores register defaults and zeroes all powers.
// ----------------------------------------------------------------------------
// field_to_power_envelope : top level
// Register file, front classifier and back-end envelope update.
// ----------------------------------------------------------------------------
module field_to_power_envelope
   import fpe_pkg::*;
#(
   parameter int CHANNELS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic signed [31:0] offset_ff;
   logic signed [7:0]  gain_ff;
   logic [30:0]        ceiling_ff;
   logic [16:0]        alpha_ff;

   logic        f_valid, f_stall, f_zero;
   logic [4:0]  f_channel;
   logic [19:0] f_arg;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         gain_ff    <= 8'sd1;
         ceiling_ff <= 31'd131072;
         alpha_ff   <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_OFFSET:  offset_ff  <= csr_wdata;
            REG_GAIN:    gain_ff    <= csr_wdata[7:0];
            REG_CEILING: ceiling_ff <= csr_wdata[30:0];
            REG_ALPHA:   alpha_ff   <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   fpe_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cfg_offset(offset_ff), .cfg_gain(gain_ff), .cfg_ceiling(ceiling_ff),
      .f_valid, .f_stall, .f_channel, .f_zero, .f_arg
   );

   fpe_back #(.CHANNELS(CHANNELS)) u_back (
      .clock, .reset, .f_valid, .f_stall, .f_channel, .f_zero, .f_arg,
      .cfg_ceiling(ceiling_ff), .cfg_alpha(alpha_ff),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// ===== src/fpe_front.sv =====
// ----------------------------------------------------------------------------
// fpe_front : sample classifier
// Takes request transactions, screens out samples that give no activity and
// forms the Q4.16 exponent argument (saturated) for the back end.
// ----------------------------------------------------------------------------
module fpe_front
   import fpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   input  logic signed [31:0] cfg_offset,
   input  logic signed [7:0]  cfg_gain,
   input  logic [30:0]        cfg_ceiling,
   output logic               f_valid,
   input  logic               f_stall,
   output logic [4:0]         f_channel,
   output logic               f_zero,
   output logic [19:0]        f_arg
);

   logic        busy_ff, busy_in;
   logic [4:0]  ch_ff, ch_in;
   logic        zero_ff, zero_in;
   logic [19:0] arg_ff, arg_in;

   logic signed [32:0] d;
   logic [9:0]         gain5;
   logic [45:0]        prod;
   logic [43:0]        t;
   logic               take;

   assign req_stall = busy_ff && f_stall;
   assign take      = req_valid && !req_stall;

   // exponent argument: t = floor(d * 5 * gain / 4), clipped at n = 15
   always_comb begin
      d     = 33'(req_data.field_sample) - 33'(cfg_offset);
      gain5 = {1'b0, cfg_gain[6:0], 2'b00} + {3'b000, cfg_gain[6:0]};
      prod  = 46'(d[31:0]) * 46'(gain5);
      t     = prod[45:2];
      zero_in = (req_data.field_sample == 32'sd0) || cfg_gain[7] || (cfg_gain == 8'sd0)
                || (cfg_ceiling <= 31'(ONE_Q16)) || d[32] || (d == 33'sd0);
      arg_in  = (t[43:20] != 24'd0) ? 20'hFFFFF : t[19:0];
      ch_in   = req_data.channel;
      busy_in = take ? 1'b1 : (busy_ff && f_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      if (take) begin
         ch_ff   <= ch_in;
         zero_ff <= zero_in;
         arg_ff  <= arg_in;
      end
   end

   assign f_valid   = busy_ff;
   assign f_channel = ch_ff;
   assign f_zero    = zero_ff;
   assign f_arg     = arg_ff;

endmodule

// ===== src/fpe_back.sv =====
// ----------------------------------------------------------------------------
// fpe_back : exponential, activity and power update
// Sequencer runs the Taylor series term by term, then divides bit-serially for
// activity unless screened out, then blends with the stored channel power.
// ----------------------------------------------------------------------------
module fpe_back
   import fpe_pkg::*;
#(
   parameter int CHANNELS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        f_valid,
   output logic        f_stall,
   input  logic [4:0]  f_channel,
   input  logic        f_zero,
   input  logic [19:0] f_arg,
   input  logic [30:0] cfg_ceiling,
   input  logic [16:0] cfg_alpha,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DIV_BITS = 17;

   typedef enum logic [2:0] {
      S_IDLE, S_TAYLOR, S_SCALE, S_DIV, S_BLEND1, S_BLEND2, S_OUT
   } state_type;

   state_type   state_ff;
   logic [4:0]  ch_ff;
   logic [15:0] frac_ff;
   logic [3:0]  nint_ff;
   logic        zero_ff;
   logic [3:0]  k_ff;
   logic        ph_ff;
   logic [29:0] q_ff;
   logic [31:0] term_ff;
   logic [31:0] sum_ff;
   logic [31:0] e_ff;
   logic [16:0] num_ff;
   logic [30:0] rem_ff;
   logic [16:0] act_ff;
   logic [4:0]  cnt_ff;
   logic [33:0] prod_ff;
   logic [16:0] power_ff;
   logic [16:0] pw_mem_ff [CHANNELS];
   logic [CHANNELS-1:0] pw_ok_ff;

   logic [47:0] tf;
   logic [31:0] rcp_m;
   logic [5:0]  rcp_s;
   logic [60:0] qm;
   logic [31:0] tk;
   logic [63:0] esc;
   logic [31:0] e_cap;
   logic [31:0] e_diff;
   logic [30:0] den;
   logic [31:0] trial;
   logic        ch_ok;
   logic [IDX_W-1:0] idx;
   logic [16:0] alpha_c, prev;
   logic [34:0] blend;
   logic [16:0] pw;

   // reciprocal of k: floor(q / k) = (q * m) >> s for any q below 2^30
   always_comb begin
      case (k_ff)
         4'd1:    begin rcp_m = 32'd1073741824; rcp_s = 6'd30; end
         4'd2:    begin rcp_m = 32'd1073741824; rcp_s = 6'd31; end
         4'd3:    begin rcp_m = 32'd1431655766; rcp_s = 6'd32; end
         4'd4:    begin rcp_m = 32'd1073741824; rcp_s = 6'd32; end
         4'd5:    begin rcp_m = 32'd1717986919; rcp_s = 6'd33; end
         4'd6:    begin rcp_m = 32'd1431655766; rcp_s = 6'd33; end
         4'd7:    begin rcp_m = 32'd1227133514; rcp_s = 6'd33; end
         4'd8:    begin rcp_m = 32'd1073741824; rcp_s = 6'd33; end
         4'd9:    begin rcp_m = 32'd1908874354; rcp_s = 6'd34; end
         4'd10:   begin rcp_m = 32'd1717986919; rcp_s = 6'd34; end
         4'd11:   begin rcp_m = 32'd1561806290; rcp_s = 6'd34; end
         4'd12:   begin rcp_m = 32'd1431655766; rcp_s = 6'd34; end
         4'd13:   begin rcp_m = 32'd1321528399; rcp_s = 6'd34; end
         default: begin rcp_m = 32'd1073741824; rcp_s = 6'd30; end
      endcase
   end

   assign f_stall = (state_ff != S_IDLE);
   assign den     = cfg_ceiling - 31'(ONE_Q16);
   assign tf      = 48'(term_ff) * 48'(frac_ff);
   assign qm      = 61'(q_ff) * 61'(rcp_m);
   assign tk      = 32'(qm >> rcp_s);
   assign esc     = 64'(exp_int_q16(nint_ff)) * 64'(sum_ff);
   assign e_cap   = (e_ff > 32'(cfg_ceiling)) ? 32'(cfg_ceiling) : e_ff;
   assign e_diff  = e_cap - 32'(ONE_Q16);
   assign trial   = {rem_ff, num_ff[16]};
   assign ch_ok   = 32'(ch_ff) < CHANNELS;
   assign idx     = IDX_W'(ch_ff);
   assign alpha_c = (cfg_alpha > ONE_Q16) ? ONE_Q16 : cfg_alpha;
   assign prev    = (ch_ok && pw_ok_ff[idx]) ? pw_mem_ff[idx] : 17'd0;
   assign blend   = 35'(prod_ff) + 35'(34'(ONE_Q16 - alpha_c) * 34'(act_ff)) + 35'd32768;
   assign pw      = (blend[32:16] > act_ff) ? blend[32:16] : act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pw_ok_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (f_valid) begin
                  ch_ff    <= f_channel;
                  zero_ff  <= f_zero;
                  nint_ff  <= f_arg[19:16];
                  frac_ff  <= f_arg[15:0];
                  term_ff  <= 32'h4000_0000;
                  sum_ff   <= 32'h4000_0000;
                  k_ff     <= 4'd1;
                  ph_ff    <= 1'b0;
                  state_ff <= S_TAYLOR;
               end
            end
            // each Taylor term: first scale by f, then divide by k
            S_TAYLOR: begin
               if (!ph_ff) begin
                  q_ff  <= tf[45:16];
                  ph_ff <= 1'b1;
               end else begin
                  term_ff <= tk;
                  sum_ff  <= sum_ff + tk;
                  k_ff    <= k_ff + 4'd1;
                  ph_ff   <= 1'b0;
                  if (k_ff == 4'(TAYLOR_TERMS)) state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               // whole part past the table stands above any ceiling
               e_ff     <= (nint_ff >= 4'(EXP_INT_LIM)) ? 32'hFFFF_FFFF
                           : 32'((esc + 64'h2000_0000) >> 30);
               rem_ff   <= '0;
               cnt_ff   <= 5'd0;
               act_ff   <= '0;
               state_ff <= zero_ff ? S_BLEND1 : S_DIV;
            end
            // restoring divide, 17 quotient bits of (e-1)<<16 / den
            S_DIV: begin
               if (cnt_ff == 5'd0) begin
                  if (e_cap <= 32'(ONE_Q16)) begin
                     state_ff <= S_BLEND1;
                  end else begin
                     // upper quotient bits are zero, so start from the top remainder
                     rem_ff <= 31'(e_diff >> 1);
                     num_ff <= {e_diff[0], 16'd0};
                     cnt_ff <= 5'd1;
                  end
               end else begin
                  num_ff <= num_ff << 1;
                  if (trial >= 32'(den)) begin
                     rem_ff <= 31'(trial - 32'(den));
                     act_ff <= {act_ff[15:0], 1'b1};
                  end else begin
                     rem_ff <= trial[30:0];
                     act_ff <= {act_ff[15:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 5'd1;
                  if (cnt_ff == 5'(DIV_BITS)) state_ff <= S_BLEND1;
               end
            end
            S_BLEND1: begin
               prod_ff  <= 34'(alpha_c) * 34'(prev);
               state_ff <= S_BLEND2;
            end
            S_BLEND2: begin
               power_ff <= pw;
               if (ch_ok) begin
                  pw_mem_ff[idx] <= pw;
                  pw_ok_ff[idx]  <= 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_data.out_channel = ch_ff;
   assign rsp_data.power       = power_ff;

   a_pw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.power <= ONE_Q16) else $error("power above one");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> f_stall) else $error("front taken while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("response dropped");

endmodule
